// ===== rtl/core/spiral_unvisited_cell_finder_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the spiral unvisited-cell finder.
// Each macro expands to a clocked concurrent assertion, or to nothing when
// the design is built for synthesis.
// ----------------------------------------------------------------------------
`ifndef SPIRAL_UNVISITED_CELL_FINDER_CORE_DEFINES_SVH
`define SPIRAL_UNVISITED_CELL_FINDER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SUCF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sucf: implication check failed");
`define SUCF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sucf: next-cycle check failed");
`else
`define SUCF_ASSERT_IMP(lbl, ante, cons)
`define SUCF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/sucf_pkg.sv =====
// ----------------------------------------------------------------------------
// Spiral unvisited-cell finder package
// Command codes, sequencer step codes and the control store of the
// microcoded sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sucf_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_POS  = 2'd1,
        CMD_NEXT = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        S_CLR   = 4'd0,
        S_IDLE  = 4'd1,
        S_LOAD  = 4'd2,
        S_POSRD = 4'd3,
        S_POSWR = 4'd4,
        S_NINIT = 4'd5,
        S_SCAN  = 4'd6,
        S_MARK  = 4'd7,
        S_RESP  = 4'd8
    } t_step;

    typedef enum logic [1:0] {
        J_NEXT = 2'd0,
        J_WAIT = 2'd1,
        J_DISP = 2'd2,
        J_SCAN = 2'd3
    } t_jmp;

    typedef enum logic [1:0] {
        C_NONE = 2'd0,
        C_IN   = 2'd1,
        C_OUT  = 2'd2,
        C_CLR  = 2'd3
    } t_cond;

    typedef enum logic {
        R_ITEM = 1'b0,
        R_CUR  = 1'b1
    } t_rsel;

    typedef enum logic [2:0] {
        WR_NONE     = 3'd0,
        WR_CLR      = 3'd1,
        WR_ITEM     = 3'd2,
        WR_ONE_ITEM = 3'd3,
        WR_ONE_HELD = 3'd4
    } t_wsel;

    typedef struct packed {
        t_jmp  jmp;
        t_cond cond;
        t_step nxt;
        t_rsel rsel;
        t_wsel wsel;
        logic  take;
        logic  init;
        logic  scan;
        logic  pos;
        logic  mark;
        logic  resp;
    } t_uword;

    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w      = '0;
        w.jmp  = J_NEXT;
        w.cond = C_NONE;
        w.nxt  = S_RESP;
        w.rsel = R_CUR;
        w.wsel = WR_NONE;
        unique case (s)
            S_CLR: begin
                w.jmp  = J_WAIT;
                w.cond = C_CLR;
                w.nxt  = S_IDLE;
                w.wsel = WR_CLR;
            end
            S_IDLE: begin
                w.jmp  = J_DISP;
                w.cond = C_IN;
                w.nxt  = S_IDLE;
                w.take = 1'b1;
            end
            S_LOAD: begin
                w.wsel = WR_ITEM;
            end
            S_POSRD: begin
                w.nxt  = S_POSWR;
                w.rsel = R_ITEM;
            end
            S_POSWR: begin
                w.wsel = WR_ONE_ITEM;
                w.pos  = 1'b1;
            end
            S_NINIT: begin
                w.nxt  = S_SCAN;
                w.init = 1'b1;
            end
            S_SCAN: begin
                w.jmp  = J_SCAN;
                w.scan = 1'b1;
            end
            S_MARK: begin
                w.wsel = WR_ONE_HELD;
                w.mark = 1'b1;
            end
            S_RESP: begin
                w.jmp  = J_WAIT;
                w.cond = C_OUT;
                w.nxt  = S_IDLE;
                w.resp = 1'b1;
            end
            default: begin
                w.nxt = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/spiral_unvisited_cell_finder_core.sv =====
// A load item passes through the load and response steps; a position item through the read,
// write and response steps. A next-goal item passes through the init step, the scan, a mark step
// when a free cell is found, and the response step; when no cell is free the scan runs over the
// whole grid. The scan reads one map cell per cycle. Items are taken one at a time, only while
// idle; the next item is taken while the last result waits, and its own result is held back until
// that one has been taken. After reset the visited map is cleared before any item is taken.
// ----------------------------------------------------------------------------
// Spiral unvisited-cell finder core
// Keeps a visited map of the grid with a goal cell and a goal-reached flag, and
// walks the grid in clockwise spiral order to find the next unvisited goal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "spiral_unvisited_cell_finder_core_defines.svh"

module spiral_unvisited_cell_finder_core #(
    parameter int ROWS = 16,
    parameter int COLS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_cmd,
    input  wire logic [3:0] i_row,
    input  wire logic [3:0] i_col,
    input  wire logic       i_cell_value,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [3:0]      o_goal_row,
    output logic [3:0]      o_goal_col,
    output logic            o_found,
    output logic            o_goal_reached,
    output logic            o_was_visited
);

    import sucf_pkg::*;

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int NCELL = ROWS * COLS;
    localparam int AW    = $clog2(NCELL);

    typedef enum logic [1:0] {
        LEG_TOP    = 2'd0,
        LEG_RIGHT  = 2'd1,
        LEG_BOTTOM = 2'd2,
        LEG_LEFT   = 2'd3
    } t_leg;

    logic      r_mem [NCELL];
    logic      r_q;

    t_step     r_step;
    t_step     n_step;
    t_uword    ctl;
    logic [AW-1:0] r_clr;

    logic [1:0]    r_cmd;
    logic [3:0]    r_row;
    logic [3:0]    r_col;
    logic          r_val;

    logic [RW-1:0] r_goal_row;
    logic [CW-1:0] r_goal_col;
    logic          r_reached;
    logic          r_found;
    logic          r_prior;

    logic [RW-1:0] r_t, r_b, n_t, n_b;
    logic [CW-1:0] r_l, r_rt, n_l, n_rt;
    logic [RW-1:0] r_cr, n_cr;
    logic [CW-1:0] r_cc, n_cc;
    t_leg          r_leg, n_leg;
    logic          r_end, n_end;
    logic          r_pv;
    logic [RW-1:0] r_pr;
    logic [CW-1:0] r_pc;

    logic          r_ovalid;
    logic [3:0]    r_o_goal_row;
    logic [3:0]    r_o_goal_col;
    logic          r_o_found;
    logic          r_o_reached;
    logic          r_o_prior;

    logic [RW+3:0] row_x;
    logic [CW+3:0] col_x;
    logic [RW-1:0] item_row;
    logic [CW-1:0] item_col;
    logic          item_inside;
    logic          goal_match;
    logic [RW+3:0] goal_row_x;
    logic [CW+3:0] goal_col_x;
    logic [AW-1:0] item_addr, cur_addr, held_addr;

    logic          mem_we;
    logic          mem_wd;
    logic [AW-1:0] mem_wa;
    logic [AW-1:0] mem_ra;

    logic          accept;
    logic          out_free;
    logic          clr_last;
    logic          cond_ok;
    logic          scan_hit;
    logic          scan_done;
    logic          ring_next;
    logic          ring_ok;
    logic [RW:0]   t_x, b_x, cr_x;
    logic [CW:0]   l_x, rt_x;

    assign ctl = ucode(r_step);

    assign row_x       = {{RW{1'b0}}, r_row};
    assign col_x       = {{CW{1'b0}}, r_col};
    assign item_row    = row_x[RW-1:0];
    assign item_col    = col_x[CW-1:0];
    assign item_inside = (row_x < (RW+4)'(ROWS)) && (col_x < (CW+4)'(COLS));
    assign goal_row_x  = {4'b0000, r_goal_row};
    assign goal_col_x  = {4'b0000, r_goal_col};
    assign goal_match  = (goal_row_x == row_x) && (goal_col_x == col_x);

    assign item_addr = AW'(AW'(item_row) * AW'(COLS)) + AW'(item_col);
    assign cur_addr  = AW'(AW'(r_cr) * AW'(COLS)) + AW'(r_cc);
    assign held_addr = AW'(AW'(r_pr) * AW'(COLS)) + AW'(r_pc);

    assign accept    = ctl.take && i_valid;
    assign out_free  = !r_ovalid || !i_stall;
    assign clr_last  = (r_clr == AW'(NCELL - 1));
    assign scan_hit  = r_pv && !r_q;
    assign scan_done = r_end && !r_pv;

    assign o_stall        = !ctl.take;
    assign o_valid        = r_ovalid;
    assign o_goal_row     = r_o_goal_row;
    assign o_goal_col     = r_o_goal_col;
    assign o_found        = r_o_found;
    assign o_goal_reached = r_o_reached;
    assign o_was_visited  = r_o_prior;

    always_comb begin
        mem_we = 1'b0;
        mem_wd = 1'b1;
        mem_wa = item_addr;
        unique case (ctl.wsel)
            WR_CLR: begin
                mem_we = 1'b1;
                mem_wd = 1'b0;
                mem_wa = r_clr;
            end
            WR_ITEM: begin
                mem_we = item_inside;
                mem_wd = r_val;
            end
            WR_ONE_ITEM: begin
                mem_we = item_inside;
            end
            WR_ONE_HELD: begin
                mem_we = 1'b1;
                mem_wa = held_addr;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
        mem_ra = (ctl.rsel == R_ITEM) ? item_addr : cur_addr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_q <= r_mem[mem_ra];
    end

    always_comb begin
        unique case (ctl.cond)
            C_IN:    cond_ok = i_valid;
            C_OUT:   cond_ok = out_free;
            C_CLR:   cond_ok = clr_last;
            default: cond_ok = 1'b1;
        endcase
        n_step = r_step;
        unique case (ctl.jmp)
            J_NEXT: n_step = ctl.nxt;
            J_WAIT: n_step = cond_ok ? ctl.nxt : r_step;
            J_DISP: begin
                if (cond_ok) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_LOAD: n_step = S_LOAD;
                        CMD_POS:  n_step = S_POSRD;
                        CMD_NEXT: n_step = S_NINIT;
                        default:  n_step = S_RESP;
                    endcase
                end
            end
            J_SCAN: begin
                if (scan_hit) begin
                    n_step = S_MARK;
                end else if (scan_done) begin
                    n_step = ctl.nxt;
                end
            end
            default: n_step = S_IDLE;
        endcase
    end

    assign t_x     = {1'b0, r_t};
    assign b_x     = {1'b0, r_b};
    assign l_x     = {1'b0, r_l};
    assign rt_x    = {1'b0, r_rt};
    assign cr_x    = {1'b0, r_cr};
    assign ring_ok = (b_x >= t_x + (RW+1)'(2)) && (rt_x >= l_x + (CW+1)'(2));

    always_comb begin
        n_cr      = r_cr;
        n_cc      = r_cc;
        n_leg     = r_leg;
        n_t       = r_t;
        n_b       = r_b;
        n_l       = r_l;
        n_rt      = r_rt;
        n_end     = r_end;
        ring_next = 1'b0;
        unique case (r_leg)
            LEG_TOP: begin
                if (r_cc < r_rt) begin
                    n_cc = r_cc + CW'(1);
                end else if (r_t < r_b) begin
                    n_cr  = r_t + RW'(1);
                    n_leg = LEG_RIGHT;
                end else begin
                    ring_next = 1'b1;
                end
            end
            LEG_RIGHT: begin
                if (r_cr < r_b) begin
                    n_cr = r_cr + RW'(1);
                end else if (r_l < r_rt) begin
                    n_cc  = r_rt - CW'(1);
                    n_leg = LEG_BOTTOM;
                end else begin
                    ring_next = 1'b1;
                end
            end
            LEG_BOTTOM: begin
                if (r_cc > r_l) begin
                    n_cc = r_cc - CW'(1);
                end else if (b_x >= t_x + (RW+1)'(2)) begin
                    n_cr  = r_b - RW'(1);
                    n_leg = LEG_LEFT;
                end else begin
                    ring_next = 1'b1;
                end
            end
            LEG_LEFT: begin
                if (cr_x > t_x + (RW+1)'(1)) begin
                    n_cr = r_cr - RW'(1);
                end else begin
                    ring_next = 1'b1;
                end
            end
            default: begin
                ring_next = 1'b1;
            end
        endcase
        if (ring_next) begin
            n_t   = r_t + RW'(1);
            n_b   = r_b - RW'(1);
            n_l   = r_l + CW'(1);
            n_rt  = r_rt - CW'(1);
            n_cr  = r_t + RW'(1);
            n_cc  = r_l + CW'(1);
            n_leg = LEG_TOP;
            n_end = !ring_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= S_CLR;
            r_clr      <= '0;
            r_ovalid   <= 1'b0;
            r_goal_row <= '0;
            r_goal_col <= '0;
            r_reached  <= 1'b0;
            r_pv       <= 1'b0;
            r_end      <= 1'b1;
        end else begin
            r_step <= n_step;
            if (ctl.wsel == WR_CLR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (accept) begin
                r_cmd   <= i_cmd;
                r_row   <= i_row;
                r_col   <= i_col;
                r_val   <= i_cell_value;
                r_found <= 1'b0;
                r_prior <= 1'b0;
            end
            if (ctl.pos && item_inside && (t_cmd'(r_cmd) == CMD_POS)) begin
                r_prior <= r_q;
                if (goal_match) begin
                    r_reached <= 1'b1;
                end
            end
            if (ctl.init) begin
                r_t   <= '0;
                r_b   <= RW'(ROWS - 1);
                r_l   <= '0;
                r_rt  <= CW'(COLS - 1);
                r_cr  <= '0;
                r_cc  <= '0;
                r_leg <= LEG_TOP;
                r_end <= 1'b0;
                r_pv  <= 1'b0;
            end
            if (ctl.scan && !scan_hit) begin
                r_pv <= !r_end;
                r_pr <= r_cr;
                r_pc <= r_cc;
                if (!r_end) begin
                    r_cr  <= n_cr;
                    r_cc  <= n_cc;
                    r_leg <= n_leg;
                    r_t   <= n_t;
                    r_b   <= n_b;
                    r_l   <= n_l;
                    r_rt  <= n_rt;
                    r_end <= n_end;
                end
            end
            if (ctl.mark) begin
                r_goal_row <= r_pr;
                r_goal_col <= r_pc;
                r_reached  <= 1'b0;
                r_found    <= 1'b1;
            end
            if (ctl.resp && out_free) begin
                r_ovalid     <= 1'b1;
                r_o_goal_row <= goal_row_x[3:0];
                r_o_goal_col <= goal_col_x[3:0];
                r_o_found    <= r_found;
                r_o_reached  <= r_reached;
                r_o_prior    <= r_prior;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    `SUCF_ASSERT_IMP(a_found_clears_reached, o_valid && o_found, !o_goal_reached)
    `SUCF_ASSERT_IMP(a_prior_only_without_found, o_valid && o_was_visited, !o_found)
    `SUCF_ASSERT_NXT(a_hit_goes_to_mark, (r_step == S_SCAN) && scan_hit, r_step == S_MARK)

endmodule

`default_nettype wire
